// File: design/x2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s_pkg
// Types, matrix coefficients and elaboration-time curve tables for the
// CIE XYZ to 8-bit sRGB encoder.
// ----------------------------------------------------------------------------
package x2s_pkg;

  // Pipeline depth: S1 products, S2 linear value, S3 encode setup,
  // eight threshold search steps, and the output register in the merge.
  localparam int X2S_LANE_STAGES = 11;
  localparam int X2S_STAGES      = X2S_LANE_STAGES + 1;
  localparam int X2S_LANES       = 3;

  localparam int X2S_COEF_W = 13;
  localparam int X2S_THR_W  = 17;
  localparam int X2S_LIN_W  = 17;

  localparam logic [X2S_LIN_W-1:0] X2S_LIN_ONE  = 17'd65536;
  localparam logic [X2S_LIN_W-1:0] X2S_LIN_KNEE = 17'd205;

  typedef logic signed [X2S_COEF_W-1:0] x2s_coef_t;

  // XYZ to linear sRGB, scaled by 65536 / 100, rows are R, G, B
  localparam x2s_coef_t [0:2][0:2] X2S_COEF = '{
    '{13'sd2124, -13'sd1007, -13'sd327},
    '{-13'sd635,  13'sd1229,  13'sd27},
    '{13'sd37,   -13'sd134,   13'sd693}
  };

  typedef logic [255:0][X2S_THR_W-1:0] x2s_thr_t;
  typedef logic [255:0][3:0]           x2s_knee_t;

  typedef struct packed {
    logic [15:0] cie_x;
    logic [15:0] cie_y;
    logic [15:0] cie_z;
  } x2s_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } x2s_out_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [X2S_STAGES-1:0] en;
  } x2s_ctrl_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic       use_rom;
    logic [7:0] rom_code;
    logic [7:0] fixed_code;
  } x2s_lane_res_t;

  // log2 in Q24: leading one gives the integer part, then 24 rounds of
  // squaring a Q30 mantissa in [1,2)
  function automatic longint x2s_lg2q(longint unsigned v);
    int              n;
    longint unsigned z;
    longint          r;
    n = 0;
    if (v == 0) begin
      return 0;
    end
    for (int i = 1; i < 63; i++) begin
      if ((v >> i) != 0) n = i;
    end
    if (n <= 30) z = v << (30 - n);
    else         z = v >> (n - 30);
    r = longint'(n) <<< 24;
    for (int b = 23; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= (64'd2 << 30)) begin
        z = z >> 1;
        r = r + (longint'(1) <<< b);
      end
    end
    return r;
  endfunction

  // Entry k: smallest ROM index whose curve value reaches code k.
  // The curve is monotonic, so the code is the count of entries <= index.
  function automatic x2s_thr_t x2s_gamma_thresholds(int gbits);
    x2s_thr_t t;
    longint   lw;
    longint   rhs;
    longint   lhs;
    int       lo;
    int       hi;
    int       mid;
    int       sh;
    t  = '0;
    sh = 16 - gbits;
    lw = x2s_lg2q(64'd269025);
    for (int k = 1; k < 256; k++) begin
      rhs = (x2s_lg2q(longint'(1000 * k + 14025)) - lw) * longint'(1048576);
      lo  = 1;
      hi  = 1 << gbits;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          lhs = longint'(436900) *
                (x2s_lg2q(longint'(mid) << sh) - (longint'(16) <<< 24));
          if (lhs >= rhs) hi = mid;
          else            lo = mid + 1;
        end
      end
      t[k] = X2S_THR_W'(lo);
    end
    return t;
  endfunction

  // Codes on the 12.92 slope for linear values up to the knee
  function automatic x2s_knee_t x2s_knee_table();
    x2s_knee_t t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i] = 4'((longint'(i) * 329460) / 6553600);
    end
    return t;
  endfunction

endpackage

// File: design/x2s_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s_ctrl
// Valid tracking and per-stage load enables; bubbles collapse so a stage
// loads whenever it is empty or its successor moves.
// ----------------------------------------------------------------------------
module x2s_ctrl
  import x2s_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output x2s_ctrl_t ctrl
);

  logic [X2S_STAGES-1:0] stage_valid;
  logic [X2S_STAGES-1:0] en;

  // Chain the enables back from the output register
  always_comb begin
    en[X2S_STAGES-1] = !stage_valid[X2S_STAGES-1] || out_ready;
    for (int i = X2S_STAGES - 2; i >= 0; i--) begin
      en[i] = !stage_valid[i] || en[i+1];
    end
  end

  // Advance valid bits along with the payload
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) stage_valid[0] <= in_valid;
      for (int i = 1; i < X2S_STAGES; i++) begin
        if (en[i]) stage_valid[i] <= stage_valid[i-1];
      end
    end
  end

  assign ctrl.en   = en;
  assign in_ready  = en[0];
  assign out_valid = stage_valid[X2S_STAGES-1];

endmodule

// File: design/x2s_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s_lane
// One output channel: matrix row, clamp to [0,1], linear or knee code, and
// an eight-step binary search over the gamma threshold table.
// ----------------------------------------------------------------------------
module x2s_lane
  import x2s_pkg::*;
#(
  parameter int LANE             = 0,
  parameter int GAMMA_INDEX_BITS = 12
) (
  input  logic          clk,
  input  logic          linear_output,
  input  x2s_in_t       in_data,
  input  x2s_ctrl_t     ctrl,
  output x2s_lane_res_t res
);

  localparam int SHIFT = 16 - GAMMA_INDEX_BITS;
  localparam int IDX_W = GAMMA_INDEX_BITS + 1;

  localparam x2s_thr_t  THR  = x2s_gamma_thresholds(GAMMA_INDEX_BITS);
  localparam x2s_knee_t KNEE = x2s_knee_table();

  localparam x2s_coef_t C_X = X2S_COEF[LANE][0];
  localparam x2s_coef_t C_Y = X2S_COEF[LANE][1];
  localparam x2s_coef_t C_Z = X2S_COEF[LANE][2];

  // S1: one product per tristimulus value
  logic signed [29:0] prod_x;
  logic signed [29:0] prod_y;
  logic signed [29:0] prod_z;
  logic               mode1;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      prod_x <= C_X * $signed({1'b0, in_data.cie_x});
      prod_y <= C_Y * $signed({1'b0, in_data.cie_y});
      prod_z <= C_Z * $signed({1'b0, in_data.cie_z});
      mode1  <= linear_output;
    end
  end

  // S2: sum, drop fraction to Q16, clamp to [0,1]
  logic signed [31:0]    acc;
  logic [X2S_LIN_W-1:0]  lin_next;
  logic [X2S_LIN_W-1:0]  lin;
  logic                  mode2;

  assign acc = 32'(prod_x) + 32'(prod_y) + 32'(prod_z);

  always_comb begin
    if (acc[31]) begin
      lin_next = '0;
    end else if (acc[31:8] > 24'(X2S_LIN_ONE)) begin
      lin_next = X2S_LIN_ONE;
    end else begin
      lin_next = acc[24:8];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      lin   <= lin_next;
      mode2 <= mode1;
    end
  end

  // S3: linear code, knee code and ROM index
  logic [24:0] lin_scaled;
  logic [7:0]  fixed_next;
  logic        rom_next;

  assign lin_scaled = {lin, 8'd0} - 25'(lin);

  always_comb begin
    if (mode2) fixed_next = lin_scaled[23:16];
    else       fixed_next = 8'(KNEE[lin[7:0]]);
    rom_next = !mode2 && (lin > X2S_LIN_KNEE);
  end

  // Search state: element 0 is S3, element j+1 follows search step j
  logic [7:0]       srch_code [9];
  logic [IDX_W-1:0] srch_idx  [9];
  logic [7:0]       srch_fix  [9];
  logic             srch_rom  [9];

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      srch_code[0] <= '0;
      srch_idx[0]  <= lin[X2S_LIN_W-1:SHIFT];
      srch_fix[0]  <= fixed_next;
      srch_rom[0]  <= rom_next;
    end
  end

  // Set one code bit per step, most significant first
  for (genvar j = 0; j < 8; j++) begin : g_search
    localparam logic [7:0] PROBE_BIT = 8'(1 << (7 - j));
    logic [7:0] probe;
    logic       take;

    assign probe = srch_code[j] | PROBE_BIT;
    assign take  = THR[probe] <= X2S_THR_W'(srch_idx[j]);

    always_ff @(posedge clk) begin
      if (ctrl.en[3+j]) begin
        srch_code[j+1] <= take ? probe : srch_code[j];
        srch_idx[j+1]  <= srch_idx[j];
        srch_fix[j+1]  <= srch_fix[j];
        srch_rom[j+1]  <= srch_rom[j];
      end
    end
  end

  assign res.use_rom    = srch_rom[8];
  assign res.rom_code   = srch_code[8];
  assign res.fixed_code = srch_fix[8];

endmodule

// File: design/x2s_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s_merge
// Pick each lane's code and hold the assembled pixel in the output register.
// ----------------------------------------------------------------------------
module x2s_merge
  import x2s_pkg::*;
(
  input  logic          clk,
  input  x2s_ctrl_t     ctrl,
  input  x2s_lane_res_t lane_res [X2S_LANES],
  output x2s_out_t      out_data
);

  logic [7:0] code [X2S_LANES];
  x2s_out_t   out_next;

  // Select ROM search result or the fixed code per lane
  always_comb begin
    for (int i = 0; i < X2S_LANES; i++) begin
      code[i] = lane_res[i].use_rom ? lane_res[i].rom_code : lane_res[i].fixed_code;
    end
    out_next.red_out   = code[0];
    out_next.green_out = code[1];
    out_next.blue_out  = code[2];
  end

  // Hold the pixel until the transfer completes
  always_ff @(posedge clk) begin
    if (ctrl.en[X2S_STAGES-1]) begin
      out_data <= out_next;
    end
  end

endmodule

// File: design/xyz_to_srgb_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_to_srgb_encoder
// CIE XYZ (Q8, white Y = 100.0) to 8-bit sRGB, linear or gamma encoded.
// ----------------------------------------------------------------------------
//  channel | signals                       | payload
//  --------+-------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data   | cie_x, cie_y, cie_z (16 b)
//  out     | out_valid, out_ready, out_data| red_out, green_out, blue_out
//  cfg     | cfg_valid, cfg_ready, cfg_data| linear_output (1 b)
//
// One pixel per clock sustained while out_ready is high; the pipeline is the two
// arithmetic stages, the encode setup, the eight-step threshold search in
// each of the three channel lanes, and the output register.
// Reset clears all valid bits and linear_output; payload registers are not
// reset. Stages load when empty or when the next stage moves, so bubbles
// collapse and input is taken while a result waits at the output until all stages fill.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module xyz_to_srgb_encoder
  import x2s_pkg::*;
#(
  parameter int GAMMA_INDEX_BITS = 12
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  x2s_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output x2s_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic          linear_output;
  x2s_ctrl_t     ctrl;
  x2s_lane_res_t lane_res [X2S_LANES];

  // Configuration register, write on transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_output <= 1'b0;
    end else if (cfg_valid) begin
      linear_output <= cfg_data;
    end
  end

  x2s_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // One lane per output channel
  for (genvar i = 0; i < X2S_LANES; i++) begin : g_lane
    x2s_lane #(
      .LANE             (i),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_lane (
      .clk           (clk),
      .linear_output (linear_output),
      .in_data       (in_data),
      .ctrl          (ctrl),
      .res           (lane_res[i])
    );
  end

  x2s_merge u_merge (
    .clk      (clk),
    .ctrl     (ctrl),
    .lane_res (lane_res),
    .out_data (out_data)
  );

endmodule

// File: tb/tb_xyz_to_srgb_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xyz_to_srgb_encoder
// Self-checking bench for the XYZ to sRGB encoder. Pixels go in through a
// valid/ready port and are scored against an in-bench fixed-point model of the
// matrix, clamp, linear scaling and gamma curve. A short list of edge pixels
// runs in both output modes first, then random pixels under three idling
// patterns, with the output mode switched between them.
// ----------------------------------------------------------------------------
module tb_xyz_to_srgb_encoder
  import x2s_pkg::*;
();

  localparam int  GAMMA_BITS    = 12;
  localparam int  ROM_SHIFT     = 16 - GAMMA_BITS;
  localparam int  PIPE_LATENCY  = 12;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  PHASE_PIXELS  = 150;
  localparam bit  MODE_GAMMA    = 1'b0;
  localparam bit  MODE_LINEAR   = 1'b1;
  localparam longint LIN_FULL   = 65536;
  localparam longint LIN_KNEE   = 205;
  localparam longint GAMMA_EXP  = 436900;

  // XYZ to linear sRGB, scaled by 65536 / 100; rows are red, green, blue
  localparam longint XYZ2RGB [3][3] = '{
    '{2124, -1007, -327},
    '{-635,  1229,   27},
    '{  37,  -134,  693}
  };

  typedef struct {
    x2s_in_t  px;
    bit       typed;
    x2s_out_t want;
  } pixel_row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  x2s_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  x2s_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;

  x2s_out_t   srgb_expect_q[$];
  longint     curve_step[256];
  bit         linear_mode;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         err_count;
  int         cycle_count;
  pixel_row_t edge_pixels[13];
  string      lane_name[3] = '{"red_out", "green_out", "blue_out"};

  xyz_to_srgb_encoder #(
    .GAMMA_INDEX_BITS(GAMMA_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log2 in Q24: integer part from the leading one, fraction by repeated
  // squaring of a Q30 mantissa
  function automatic longint log2_q24(longint unsigned v);
    int              msb;
    longint unsigned mant;
    longint          res;
    if (v == 0) return 0;
    msb = 0;
    while (msb < 62 && (v >> (msb + 1)) != 0) msb++;
    if (msb <= 30) mant = v << (30 - msb);
    else           mant = v >> (msb - 30);
    res = longint'(msb) << 24;
    for (int b = 23; b >= 0; b--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        res  = res + (longint'(1) << b);
      end
    end
    return res;
  endfunction

  // Gamma code: count of codes whose curve threshold the ROM point reaches
  function automatic int gamma_code(longint lin);
    longint point;
    longint lhs;
    int     code;
    point = (lin >> ROM_SHIFT) << ROM_SHIFT;
    if (point == 0) return 0;
    lhs  = GAMMA_EXP * (log2_q24(point) - (longint'(16) << 24));
    code = 0;
    for (int k = 1; k < 256; k++) begin
      if (lhs >= curve_step[k]) code++;
    end
    return code;
  endfunction

  // Matrix row, clamp to [0,1], then linear or gamma encode
  function automatic logic [7:0] encode_lane(int row, x2s_in_t px);
    longint acc;
    longint lin;
    longint code;
    acc = XYZ2RGB[row][0] * longint'(px.cie_x) + XYZ2RGB[row][1] * longint'(px.cie_y) +
          XYZ2RGB[row][2] * longint'(px.cie_z);
    lin = (acc < 0) ? 0 : (acc >>> 8);
    if (lin > LIN_FULL) lin = LIN_FULL;
    if (linear_mode == MODE_LINEAR) code = (255 * lin) >>> 16;
    else if (lin <= LIN_KNEE)       code = (lin * 329460) / 6553600;
    else                            code = gamma_code(lin);
    if (code > 255) code = 255;
    return code[7:0];
  endfunction

  function automatic x2s_out_t srgb_of(x2s_in_t px);
    x2s_out_t res;
    res.red_out   = encode_lane(0, px);
    res.green_out = encode_lane(1, px);
    res.blue_out  = encode_lane(2, px);
    return res;
  endfunction

  // Mix of full-range, realistic, dark and edge pixels
  function automatic x2s_in_t random_pixel();
    x2s_in_t px;
    int      kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      px.cie_x = 16'($urandom_range(0, 65535));
      px.cie_y = 16'($urandom_range(0, 65535));
      px.cie_z = 16'($urandom_range(0, 65535));
    end else if (kind <= 6) begin
      px.cie_x = 16'($urandom_range(0, 30000));
      px.cie_y = 16'($urandom_range(0, 30000));
      px.cie_z = 16'($urandom_range(0, 30000));
    end else if (kind <= 8) begin
      px.cie_x = 16'($urandom_range(0, 600));
      px.cie_y = 16'($urandom_range(0, 600));
      px.cie_z = 16'($urandom_range(0, 600));
    end else begin
      px.cie_x = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      px.cie_y = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(0, 65535));
      px.cie_z = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return px;
  endfunction

  // Present one pixel, hold until the transfer, then log its expected color
  task automatic send_pixel(x2s_in_t px, bit typed, x2s_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    srgb_expect_q.push_back(typed ? want : srgb_of(px));
  endtask

  // Wait until every expected pixel has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (srgb_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(bit mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    linear_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count, bit hold_midway);
    for (int i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) wait_drained();
      send_pixel(random_pixel(), 1'b0, '0);
    end
    wait_drained();
  endtask

  // Drive out_ready at the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Score each output transfer against the oldest expected pixel
  always @(posedge clk) begin : score_pixels
    x2s_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (srgb_expect_q.size() == 0) begin
        $display("%0t: pixel %h with none expected", $time, out_data);
        err_count++;
      end else begin
        want = srgb_expect_q.pop_front();
        for (int c = 0; c < 3; c++) begin
          if (out_data[23 - 8 * c -: 8] !== want[23 - 8 * c -: 8]) begin
            $display("%0t: %s expected %0d got %0d", $time, lane_name[c],
                     want[23 - 8 * c -: 8], out_data[23 - 8 * c -: 8]);
            err_count++;
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    linear_mode   = MODE_GAMMA;
    send_idle_pct = 17;
    recv_idle_pct = 78;
    err_count     = 0;
    cycle_count   = 0;

    // Curve thresholds for codes 1..255 at 44 fractional bits
    curve_step[0] = 0;
    for (int k = 1; k < 256; k++) begin
      curve_step[k] = (log2_q24(64'(1000 * k + 14025)) - log2_q24(64'd269025)) * 1048576;
    end

    // Black, full scale, single axes, white, knee and near-full points
    edge_pixels = '{
      '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{'{16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{'{16'hFFFF, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
      '{'{16'd24332, 16'd25600, 16'd27874}, 1'b0, '0},
      '{'{16'd0, 16'd0, 16'd76}, 1'b0, '0},
      '{'{16'd0, 16'd0, 16'd77}, 1'b0, '0},
      '{'{16'd0, 16'd13651, 16'd0}, 1'b0, '0},
      '{'{16'd1, 16'd1, 16'd1}, 1'b0, '0},
      '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
      '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
      '{'{16'h8000, 16'h0000, 16'h0000}, 1'b0, '0}
    };

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Edge pixels in both modes
    write_mode(MODE_GAMMA);
    foreach (edge_pixels[i]) send_pixel(edge_pixels[i].px, edge_pixels[i].typed,
                                        edge_pixels[i].want);
    wait_drained();
    write_mode(MODE_LINEAR);
    foreach (edge_pixels[i]) send_pixel(edge_pixels[i].px, edge_pixels[i].typed,
                                        edge_pixels[i].want);
    wait_drained();

    // Random pixels: slow sink, then slow source, then full rate
    write_mode(MODE_GAMMA);
    run_random(PHASE_PIXELS, 1'b0);
    send_idle_pct = 78;
    recv_idle_pct = 17;
    write_mode(MODE_LINEAR);
    run_random(PHASE_PIXELS, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(MODE_GAMMA);
    run_random(PHASE_PIXELS, 1'b1);

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
